FILE: hdl/mrem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mrem_pkg;

  localparam int MemRegions  = 16;
  localparam int ExclRegions = 16;
  localparam int PageShift   = 12;
  localparam int MaxRanges   = 2 * MemRegions;

  localparam logic [1:0] FUNC_ADD_MEM  = 2'd0;
  localparam logic [1:0] FUNC_ADD_EXCL = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] region_addr;
    logic [31:0] region_size;
    logic [1:0]  region_flags;
    logic [1:0]  select_mask;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [32:0] range_start;
    logic [32:0] range_end;
    logic [20:0] range_pages;
    logic [24:0] total_pages;
    logic [24:0] avail_pages;
    logic        last;
  } out_item_t;

  // One stored entry of either table; memory entries leave kind unused.
  typedef struct packed {
    logic [31:0] start;
    logic [32:0] length;
    logic [1:0]  kind;
  } entry_t;

  // Insertion command broadcast along a chain of cells.
  typedef struct packed {
    logic       ins;
    logic [4:0] count;
    entry_t     ent;
  } ins_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEM_LOAD,
    ST_EXCL_STEP,
    ST_MEM_FINISH,
    ST_TERM
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/mrem_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module mrem_cell (
  input  wire logic               clk,
  input  wire logic [4:0]         idx,
  input  wire mrem_pkg::ins_cmd_t cmd,
  input  wire mrem_pkg::entry_t   prev_ent,
  input  wire logic               prev_gt,
  input  wire logic               rot,
  input  wire mrem_pkg::entry_t   next_ent,
  output mrem_pkg::entry_t        ent,
  output logic                    gt
);

  mrem_pkg::entry_t ent_r, ent_nxt;
  logic             occ;

  // An occupied cell whose start is above the new one moves up a slot.
  assign occ = idx < cmd.count;
  assign gt  = occ && (cmd.ent.start < ent_r.start);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins) begin
      if (gt) begin
        ent_nxt = prev_gt ? prev_ent : cmd.ent;
      end else if (idx == cmd.count && !prev_gt) begin
        ent_nxt = cmd.ent;
      end else if (idx == cmd.count) begin
        ent_nxt = prev_ent;
      end
    end else if (rot) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/mrem_chain.sv
`timescale 1ns / 1ps
`default_nettype none
module mrem_chain (
  input  wire logic               clk,
  input  wire mrem_pkg::ins_cmd_t cmd,
  input  wire logic               rot,
  input  wire logic [4:0]         len,
  output mrem_pkg::entry_t        head
);

  localparam int N = (mrem_pkg::MemRegions > mrem_pkg::ExclRegions) ?
                     mrem_pkg::MemRegions : mrem_pkg::ExclRegions;

  mrem_pkg::entry_t ents [N];
  logic             gts  [N];

  // Rotation shifts entries toward cell 0 and wraps the head to slot len-1.
  for (genvar i = 0; i < N; i++) begin : g_cell
    mrem_pkg::entry_t pe, ne;
    logic             pg;
    if (i == 0) begin : g_first
      assign pe = ents[0];
      assign pg = 1'b0;
    end else begin : g_rest
      assign pe = ents[i-1];
      assign pg = gts[i-1];
    end
    if (i == N - 1) begin : g_end
      assign ne = ents[0];
    end else begin : g_mid
      assign ne = (5'(i) == len - 5'd1) ? ents[0] : ents[i+1];
    end
    mrem_cell u_cell (
      .clk(clk), .idx(5'(i)), .cmd(cmd), .prev_ent(pe), .prev_gt(pg),
      .rot(rot), .next_ent(ne), .ent(ents[i]), .gt(gts[i])
    );
  end

  assign head = ents[0];

endmodule
`default_nettype wire

FILE: hdl/memory_region_exclusion_mapper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// An add offers its result in the cycle after acceptance and the next transaction is taken
// once that result leaves; the chain cells do the sorted insert as the add is accepted.
// Compute walks the exclusion chain once per memory region by rotating it.
// One transaction is in progress at a time.
// Synchronous active-low reset empties both tables; entry contents are not cleared.
module memory_region_exclusion_mapper_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mrem_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mrem_pkg::out_item_t      out_data
);

  localparam logic [32:0] PgMask = 33'((64'd1 << mrem_pkg::PageShift) - 1);
  localparam logic [32:0] PgSize = PgMask + 33'd1;
  localparam logic [32:0] Top    = 33'h1_0000_0000;

  mrem_pkg::state_t state_r, state_nxt;
  logic [4:0] mcnt_r, mcnt_nxt, xcnt_r, xcnt_nxt;
  logic [4:0] hi_r, hi_nxt, ei_r, ei_nxt;
  logic [1:0] mask_r, mask_nxt;
  logic [32:0] st_r, st_nxt, en_r, en_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  n_r, n_nxt;
  logic        over_r, over_nxt;
  logic [24:0] tot_r, tot_nxt, av_r, av_nxt;
  logic        ov_r, ov_nxt;
  mrem_pkg::out_item_t od_r, od_nxt;
  mrem_pkg::ins_cmd_t  mcmd, xcmd;
  logic        mrot, xrot;
  mrem_pkg::entry_t mhead, xhead;

  // Page trimming of new entries.
  logic [32:0] a, s, r, adj, ml, xst, xl;
  always_comb begin
    a = {1'b0, in_data.region_addr};
    s = {1'b0, in_data.region_size};
    if (a == 33'd0) begin
      a = PgSize;
      s = (s >= PgSize) ? s - PgSize : 33'd0;
    end
    r = (a + PgMask) & ~PgMask;
    adj = r - a;
    if (r >= Top) begin
      r  = a & ~PgMask;
      ml = 33'd0;
    end else begin
      ml = (s > adj) ? ((s - adj) & ~PgMask) : 33'd0;
      if (ml > Top - r) ml = Top - r;
    end
    xst = {1'b0, in_data.region_addr} & ~PgMask;
    xl  = ({1'b0, in_data.region_size} + ({1'b0, in_data.region_addr} - xst) + PgMask)
          & ~PgMask;
  end

  wire accept = in_valid && !in_stall;
  wire full_m = mcnt_r >= 5'(mrem_pkg::MemRegions);
  wire full_x = xcnt_r >= 5'(mrem_pkg::ExclRegions);

  always_comb begin
    mcmd = '0;
    xcmd = '0;
    mcmd.count = mcnt_r;
    xcmd.count = xcnt_r;
    mcmd.ent   = '{start: r[31:0], length: ml, kind: 2'd0};
    xcmd.ent   = '{start: xst[31:0], length: {1'b0, xl[31:0]} | {xl[32], 32'd0},
                   kind: in_data.region_flags};
    mcmd.ins = accept && in_data.func == mrem_pkg::FUNC_ADD_MEM && !full_m;
    xcmd.ins = accept && in_data.func == mrem_pkg::FUNC_ADD_EXCL && !full_x;
  end

  mrem_chain u_mem (.clk(clk), .cmd(mcmd), .rot(mrot), .len(mcnt_r), .head(mhead));
  mrem_chain u_excl (.clk(clk), .cmd(xcmd), .rot(xrot), .len(xcnt_r), .head(xhead));

  // A widened exclusion near the top can end at 2^33, so its bounds carry 34 bits.
  logic [33:0] xs, xe, sw, ew;
  logic [32:0] pend, ps;
  always_comb begin
    state_nxt = state_r;
    mcnt_nxt = mcnt_r; xcnt_nxt = xcnt_r; hi_nxt = hi_r; ei_nxt = ei_r;
    mask_nxt = mask_r; st_nxt = st_r; en_nxt = en_r; done_nxt = done_r;
    n_nxt = n_r; over_nxt = over_r; tot_nxt = tot_r; av_nxt = av_r;
    ov_nxt = out_valid && out_stall; od_nxt = od_r;
    in_stall = (state_r != mrem_pkg::ST_IDLE) || ov_r;
    mrot = 1'b0; xrot = 1'b0;
    xs = {2'b0, xhead.start};
    xe = xs + {1'b0, xhead.length};
    sw = {1'b0, st_r};
    ew = {1'b0, en_r};
    pend = 33'd0; ps = 33'd0;
    case (state_r)
      mrem_pkg::ST_IDLE: begin
        if (accept) begin
          od_nxt = '0;
          od_nxt.last = 1'b1;
          ov_nxt = 1'b1;
          case (in_data.func)
            mrem_pkg::FUNC_ADD_MEM: begin
              od_nxt.status = full_m;
              if (!full_m) mcnt_nxt = mcnt_r + 5'd1;
            end
            mrem_pkg::FUNC_ADD_EXCL: begin
              od_nxt.status = full_x;
              if (!full_x) xcnt_nxt = xcnt_r + 5'd1;
            end
            mrem_pkg::FUNC_COMPUTE: begin
              ov_nxt = 1'b0;
              mask_nxt = in_data.select_mask;
              hi_nxt = 5'd0; n_nxt = 6'd0; over_nxt = 1'b0;
              tot_nxt = 25'd0; av_nxt = 25'd0;
              state_nxt = (mcnt_r == 5'd0) ? mrem_pkg::ST_TERM : mrem_pkg::ST_MEM_LOAD;
            end
            default: ;
          endcase
        end
      end
      mrem_pkg::ST_MEM_LOAD: begin
        st_nxt = {1'b0, mhead.start};
        en_nxt = {1'b0, mhead.start} + {1'b0, mhead.length[31:0]};
        tot_nxt = tot_r + 25'(mhead.length[31:0] >> mrem_pkg::PageShift);
        ei_nxt = 5'd0; done_nxt = 1'b0;
        state_nxt = (xcnt_r == 5'd0) ? mrem_pkg::ST_MEM_FINISH : mrem_pkg::ST_EXCL_STEP;
      end
      mrem_pkg::ST_EXCL_STEP: begin
        if (!ov_r || !out_stall) begin
          xrot = 1'b1;
          ei_nxt = ei_r + 5'd1;
          if (!done_r && (xhead.kind & mask_r) != 2'd0 && !(xe <= sw)) begin
            if (xs >= ew) begin
              done_nxt = 1'b1;
            end else if (sw >= xs && ew <= xe) begin
              st_nxt = xe[32:0]; en_nxt = xe[32:0]; done_nxt = 1'b1;
            end else if (xs > sw && xe < ew) begin
              ps = xs[32:0] - st_r;
              av_nxt = av_r + 25'(ps >> mrem_pkg::PageShift);
              if (n_r < 6'(mrem_pkg::MaxRanges)) begin
                od_nxt = '0;
                od_nxt.range_start = st_r;
                od_nxt.range_end = xs[32:0];
                od_nxt.range_pages = 21'(ps >> mrem_pkg::PageShift);
                ov_nxt = 1'b1;
                n_nxt = n_r + 6'd1;
              end else begin
                over_nxt = 1'b1;
              end
              st_nxt = xe[32:0];
            end else if (xs >= sw && xs <= ew) begin
              en_nxt = xs[32:0];
            end else if (xe >= sw && xe <= ew) begin
              st_nxt = xe[32:0];
            end
          end
          if (ei_r == xcnt_r - 5'd1) state_nxt = mrem_pkg::ST_MEM_FINISH;
        end
      end
      mrem_pkg::ST_MEM_FINISH: begin
        if (!ov_r || !out_stall) begin
          pend = en_r - st_r;
          if (en_r > st_r) begin
            av_nxt = av_r + 25'(pend >> mrem_pkg::PageShift);
            if (n_r < 6'(mrem_pkg::MaxRanges)) begin
              od_nxt = '0;
              od_nxt.range_start = st_r;
              od_nxt.range_end = en_r;
              od_nxt.range_pages = 21'(pend >> mrem_pkg::PageShift);
              ov_nxt = 1'b1;
              n_nxt = n_r + 6'd1;
            end else begin
              over_nxt = 1'b1;
            end
          end
          mrot = 1'b1;
          hi_nxt = hi_r + 5'd1;
          state_nxt = (hi_r == mcnt_r - 5'd1) ? mrem_pkg::ST_TERM : mrem_pkg::ST_MEM_LOAD;
        end
      end
      mrem_pkg::ST_TERM: begin
        if (!ov_r || !out_stall) begin
          od_nxt = '0;
          od_nxt.status = over_r;
          od_nxt.total_pages = tot_r;
          od_nxt.avail_pages = av_r;
          od_nxt.last = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = mrem_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mrem_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrem_pkg::ST_IDLE;
      mcnt_r <= '0; xcnt_r <= '0; ov_r <= 1'b0;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      mcnt_r <= mcnt_nxt; xcnt_r <= xcnt_nxt; ov_r <= ov_nxt;
      n_r <= n_nxt;
    end
    hi_r <= hi_nxt; ei_r <= ei_nxt; mask_r <= mask_nxt;
    st_r <= st_nxt; en_r <= en_nxt; done_r <= done_nxt;
    over_r <= over_nxt; tot_r <= tot_nxt; av_r <= av_nxt;
    od_r <= od_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mcnt_r <= 5'(mrem_pkg::MemRegions) && xcnt_r <= 5'(mrem_pkg::ExclRegions))
    else $error("table count out of range");
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != mrem_pkg::ST_IDLE |-> in_stall)
    else $error("accept while busy");
  a_range_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 6'(mrem_pkg::MaxRanges))
    else $error("range count over cap");

endmodule
`default_nettype wire
